// File: sv/annexb_nal_codec_keyframe_scanner_assert.svh
`ifndef ANNEXB_NAL_CODEC_KEYFRAME_SCANNER_ASSERT_SVH
`define ANNEXB_NAL_CODEC_KEYFRAME_SCANNER_ASSERT_SVH

// check cons in the same cycle as ante
`define NALKF_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// check cons in the cycle after ante
`define NALKF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/nalkf_pkg.sv
`timescale 1ns / 1ps
package nalkf_pkg;

    localparam int SCORE_BITS_DEF = 16;
    localparam int CFG_ADDR_W     = 3;

    localparam logic [CFG_ADDR_W-3:0] REG_KEYFRAME_CODEC = '0;

    localparam logic CODEC_AVC  = 1'b0;
    localparam logic CODEC_HEVC = 1'b1;

    localparam logic [1:0] VERDICT_NONE = 2'd0;
    localparam logic [1:0] VERDICT_AVC  = 2'd1;
    localparam logic [1:0] VERDICT_HEVC = 2'd2;

    localparam logic [1:0] KF_NONE  = 2'd0;
    localparam logic [1:0] KF_IDR   = 2'd1;
    localparam logic [1:0] KF_SHORT = 2'd2;

    localparam logic [1:0] INC_NONE = 2'd0;
    localparam logic [1:0] INC_ONE  = 2'd1;
    localparam logic [1:0] INC_PSET = 2'd3;

    localparam logic [2:0] SHORT_LIMIT  = 3'd4;
    localparam logic [1:0] ZERO_RUN_MAX = 2'd2;
    localparam logic [7:0] START_BYTE   = 8'h01;
    localparam logic [7:0] ZERO_BYTE    = 8'h00;

    localparam logic [4:0] AVC_T_SLICE = 5'd1;
    localparam logic [4:0] AVC_T_IDR   = 5'd5;
    localparam logic [4:0] AVC_T_SEI   = 5'd6;
    localparam logic [4:0] AVC_T_SPS   = 5'd7;
    localparam logic [4:0] AVC_T_PPS   = 5'd8;
    localparam logic [4:0] AVC_T_AUD   = 5'd9;

    localparam logic [5:0] HEVC_T_TRAIL_R = 6'd1;
    localparam logic [5:0] HEVC_T_IDR_W   = 6'd19;
    localparam logic [5:0] HEVC_T_IDR_N   = 6'd20;
    localparam logic [5:0] HEVC_T_VPS     = 6'd32;
    localparam logic [5:0] HEVC_T_SPS     = 6'd33;
    localparam logic [5:0] HEVC_T_PPS     = 6'd34;
    localparam logic [5:0] HEVC_T_AUD     = 6'd35;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [1:0] codec_verdict;
        logic [1:0] keyframe_status;
    } t_out_item;

    typedef struct packed {
        logic [1:0] avc_inc;
        logic [1:0] hevc_inc;
        logic       idr;
        logic       last;
    } t_cls;

endpackage

// File: sv/annexb_nal_codec_keyframe_scanner.sv
`timescale 1ns / 1ps
// o_out_valid rises after the last byte passes the queue into the output register, if that is free.
// Throughput: one byte per cycle unless the queue is full or a last byte waits for a busy output.
// The input stays ready while a result waits, until the queue fills.
// Reset: synchronous, active low; clears parser state, scores, queue and keyframe_codec.
module annexb_nal_codec_keyframe_scanner #(
    parameter int SCORE_BITS = nalkf_pkg::SCORE_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  nalkf_pkg::t_in_item                 i_in_item,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output nalkf_pkg::t_out_item                o_out_item,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [nalkf_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);
    import nalkf_pkg::*;

    logic r_codec;
    logic w_sel_codec;
    logic w_q_ready;
    logic w_push;
    t_cls w_front_cls;
    logic w_q_valid;
    logic w_pop;
    t_cls w_q_cls;

    assign pready      = 1'b1;
    assign w_sel_codec = (paddr[CFG_ADDR_W-1:2] == REG_KEYFRAME_CODEC);
    assign prdata      = w_sel_codec ? {31'd0, r_codec} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_codec <= CODEC_AVC;
        end else if (psel && penable && pwrite && pready && w_sel_codec) begin
            r_codec <= pwdata[0];
        end
    end

    nalkf_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .i_item    (i_in_item),
        .i_codec   (r_codec),
        .i_q_ready (w_q_ready),
        .o_ready   (o_in_ready),
        .o_push    (w_push),
        .o_cls     (w_front_cls)
    );

    nalkf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cls   (w_front_cls),
        .o_ready (w_q_ready),
        .o_valid (w_q_valid),
        .i_pop   (w_pop),
        .o_cls   (w_q_cls)
    );

    nalkf_back #(
        .SCORE_BITS (SCORE_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_q_valid),
        .i_cls   (w_q_cls),
        .o_pop   (w_pop),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_item  (o_out_item)
    );

endmodule

// File: sv/nalkf_front.sv
`timescale 1ns / 1ps
module nalkf_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  nalkf_pkg::t_in_item i_item,
    input  logic              i_codec,
    input  logic              i_q_ready,
    output logic              o_ready,
    output logic              o_push,
    output nalkf_pkg::t_cls   o_cls
);
    import nalkf_pkg::*;

    logic [1:0] r_zero_run;
    logic [1:0] n_zero_run;
    logic       r_hdr_exp;
    logic       n_hdr_exp;
    logic [4:0] w_t4;
    logic [5:0] w_t5;

    function automatic logic [1:0] f_avc_inc(logic [4:0] t);
        logic [1:0] inc;
        inc = INC_NONE;
        if (t == AVC_T_SPS || t == AVC_T_PPS) begin
            inc = INC_PSET;
        end else if (t == AVC_T_IDR || t == AVC_T_SLICE || t == AVC_T_AUD || t == AVC_T_SEI) begin
            inc = INC_ONE;
        end
        return inc;
    endfunction

    function automatic logic [1:0] f_hevc_inc(logic [5:0] t);
        logic [1:0] inc;
        inc = INC_NONE;
        if (t == HEVC_T_VPS || t == HEVC_T_SPS || t == HEVC_T_PPS) begin
            inc = INC_PSET;
        end else if (t == HEVC_T_IDR_W || t == HEVC_T_IDR_N || t == HEVC_T_TRAIL_R ||
                     t == HEVC_T_AUD) begin
            inc = INC_ONE;
        end
        return inc;
    endfunction

    assign o_ready = i_q_ready;
    assign o_push  = i_valid && i_q_ready;
    assign w_t4    = i_item.data_byte[4:0];
    assign w_t5    = i_item.data_byte[6:1];

    always_comb begin
        o_cls          = '0;
        o_cls.last     = i_item.last_byte;
        n_zero_run     = r_zero_run;
        n_hdr_exp      = r_hdr_exp;
        if (r_hdr_exp) begin
            o_cls.avc_inc  = f_avc_inc(w_t4);
            o_cls.hevc_inc = i_item.last_byte ? INC_NONE : f_hevc_inc(w_t5);
            if (i_codec == CODEC_AVC) begin
                o_cls.idr = (w_t4 == AVC_T_IDR);
            end else begin
                o_cls.idr = (w_t5 == HEVC_T_IDR_W) || (w_t5 == HEVC_T_IDR_N);
            end
            n_hdr_exp  = 1'b0;
            n_zero_run = 2'd0;
        end else if (i_item.data_byte == START_BYTE && r_zero_run >= ZERO_RUN_MAX) begin
            n_hdr_exp  = 1'b1;
            n_zero_run = 2'd0;
        end else if (i_item.data_byte == ZERO_BYTE) begin
            if (r_zero_run < ZERO_RUN_MAX) begin
                n_zero_run = r_zero_run + 2'd1;
            end
        end else begin
            n_zero_run = 2'd0;
        end
        if (i_item.last_byte) begin
            n_hdr_exp  = 1'b0;
            n_zero_run = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_run <= 2'd0;
            r_hdr_exp  <= 1'b0;
        end else if (o_push) begin
            r_zero_run <= n_zero_run;
            r_hdr_exp  <= n_hdr_exp;
        end
    end

endmodule

// File: sv/nalkf_queue.sv
`timescale 1ns / 1ps
`include "annexb_nal_codec_keyframe_scanner_assert.svh"
module nalkf_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  nalkf_pkg::t_cls i_cls,
    output logic            o_ready,
    output logic            o_valid,
    input  logic            i_pop,
    output nalkf_pkg::t_cls o_cls
);
    import nalkf_pkg::*;

    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    t_cls       r_head;
    t_cls       n_head;
    t_cls       r_tail;
    t_cls       n_tail;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cls   = r_head;

    always_comb begin
        n_cnt  = r_cnt;
        n_head = r_head;
        n_tail = r_tail;
        case (r_cnt)
            2'd0: begin
                if (i_push) begin
                    n_head = i_cls;
                    n_cnt  = 2'd1;
                end
            end
            2'd1: begin
                if (i_push && i_pop) begin
                    n_head = i_cls;
                end else if (i_push) begin
                    n_tail = i_cls;
                    n_cnt  = 2'd2;
                end else if (i_pop) begin
                    n_cnt = 2'd0;
                end
            end
            2'd2: begin
                if (i_pop) begin
                    n_head = r_tail;
                    n_cnt  = 2'd1;
                end
            end
            default: begin
                n_cnt = 2'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_head <= n_head;
        r_tail <= n_tail;
    end

    `NALKF_ASSERT_NOW(a_cnt_range, i_clk, i_rst_n, 1'b1, r_cnt != 2'd3, "queue count out of range")
    `NALKF_ASSERT_NOW(a_no_pop_empty, i_clk, i_rst_n, i_pop, r_cnt != 2'd0, "pop from empty queue")
    `NALKF_ASSERT_NEXT(a_full_hold, i_clk, i_rst_n, r_cnt == 2'd2 && !i_pop, r_cnt == 2'd2,
                       "full queue lost an entry")

endmodule

// File: sv/nalkf_back.sv
`timescale 1ns / 1ps
`include "annexb_nal_codec_keyframe_scanner_assert.svh"
module nalkf_back #(
    parameter int SCORE_BITS = nalkf_pkg::SCORE_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  nalkf_pkg::t_cls      i_cls,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_ready,
    output nalkf_pkg::t_out_item o_item
);
    import nalkf_pkg::*;

    logic [SCORE_BITS-1:0] r_avc;
    logic [SCORE_BITS-1:0] n_avc;
    logic [SCORE_BITS-1:0] r_hevc;
    logic [SCORE_BITS-1:0] n_hevc;
    logic                  r_idr;
    logic                  n_idr;
    logic [2:0]            r_short;
    logic [2:0]            n_short;
    logic                  r_out_valid;
    t_out_item             r_out;
    t_out_item             n_out;
    logic                  w_pop_last;

    function automatic logic [SCORE_BITS-1:0] f_sat_add(logic [SCORE_BITS-1:0] s,
                                                        logic [1:0] inc);
        logic [SCORE_BITS:0] sum;
        sum = {1'b0, s} + {{(SCORE_BITS-1){1'b0}}, inc};
        return sum[SCORE_BITS] ? {SCORE_BITS{1'b1}} : sum[SCORE_BITS-1:0];
    endfunction

    assign o_pop      = i_valid && (!i_cls.last || !r_out_valid || i_ready);
    assign w_pop_last = o_pop && i_cls.last;
    assign o_valid    = r_out_valid;
    assign o_item     = r_out;

    always_comb begin
        n_avc   = f_sat_add(r_avc, i_cls.avc_inc);
        n_hevc  = f_sat_add(r_hevc, i_cls.hevc_inc);
        n_idr   = r_idr || i_cls.idr;
        n_short = (r_short == SHORT_LIMIT) ? SHORT_LIMIT : r_short + 3'd1;
        if (n_short < SHORT_LIMIT) begin
            n_out.codec_verdict   = VERDICT_NONE;
            n_out.keyframe_status = KF_SHORT;
        end else begin
            if (n_avc == '0 && n_hevc == '0) begin
                n_out.codec_verdict = VERDICT_NONE;
            end else if (n_hevc > n_avc) begin
                n_out.codec_verdict = VERDICT_HEVC;
            end else begin
                n_out.codec_verdict = VERDICT_AVC;
            end
            n_out.keyframe_status = n_idr ? KF_IDR : KF_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avc       <= '0;
            r_hevc      <= '0;
            r_idr       <= 1'b0;
            r_short     <= 3'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_pop_last) begin
                r_avc       <= '0;
                r_hevc      <= '0;
                r_idr       <= 1'b0;
                r_short     <= 3'd0;
                r_out_valid <= 1'b1;
            end else begin
                if (o_pop) begin
                    r_avc   <= n_avc;
                    r_hevc  <= n_hevc;
                    r_idr   <= n_idr;
                    r_short <= n_short;
                end
                if (i_ready) begin
                    r_out_valid <= 1'b0;
                end
            end
        end
        if (w_pop_last) begin
            r_out <= n_out;
        end
    end

    `NALKF_ASSERT_NEXT(a_clear_after_last, i_clk, i_rst_n, w_pop_last,
                       r_avc == '0 && r_hevc == '0 && !r_idr && r_short == 3'd0,
                       "buffer state not cleared after last byte")
    `NALKF_ASSERT_NOW(a_short_verdict, i_clk, i_rst_n,
                      r_out_valid && r_out.keyframe_status == KF_SHORT,
                      r_out.codec_verdict == VERDICT_NONE, "short buffer gave a codec")
    `NALKF_ASSERT_NOW(a_short_range, i_clk, i_rst_n, 1'b1, r_short <= SHORT_LIMIT,
                      "byte count past limit")

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
module testbench;
    import nalkf_pkg::*;

    localparam int SB            = SCORE_BITS_DEF;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 400;
    localparam int LIMIT_CYCLES  = 3_000_000;
    localparam int RANDOM_ITEMS  = 500;
    localparam int RANDOM_PHASES = 6;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_ready;
    t_in_item    i_in_item   = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out_item   o_out_item;
    logic        psel        = 1'b0;
    logic        penable     = 1'b0;
    logic        pwrite      = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata      = '0;
    logic [31:0] prdata;
    logic        pready;

    annexb_nal_codec_keyframe_scanner u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // scanner copy used for prediction
    logic          codec_sel = CODEC_AVC;
    logic [1:0]    zero_cnt  = '0;
    logic          hdr_next  = 1'b0;
    logic [SB-1:0] avc_sc    = '0;
    logic [SB-1:0] hevc_sc   = '0;
    logic          idr_flag  = 1'b0;
    logic [2:0]    seen_cnt  = '0;

    t_in_item  byte_feed[$];
    t_out_item verdict_q[$];
    t_out_item want;

    int n_fed          = 0;
    int n_taken        = 0;
    int n_verdicts_due = 0;
    int n_verdicts_got = 0;
    int fails          = 0;
    int cycle_cnt      = 0;

    int gap_left   = 0;
    int burst_left = 0;
    int hold_left  = 0;
    int mode_left  = 0;
    int stall_mode = 0;
    logic press_req  = 1'b0;
    logic press_done = 1'b0;

    logic [4:0] avc_kinds [6]  = '{AVC_T_SLICE, AVC_T_IDR, AVC_T_SEI,
                                   AVC_T_SPS, AVC_T_PPS, AVC_T_AUD};
    logic [5:0] hevc_kinds [7] = '{HEVC_T_TRAIL_R, HEVC_T_IDR_W, HEVC_T_IDR_N, HEVC_T_VPS,
                                   HEVC_T_SPS, HEVC_T_PPS, HEVC_T_AUD};

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic [SB-1:0] sat_add(input logic [SB-1:0] s, input logic [1:0] inc);
        logic [SB:0] sum;
        sum = {1'b0, s} + {{(SB-1){1'b0}}, inc};
        return sum[SB] ? '1 : sum[SB-1:0];
    endfunction

    task automatic predict_byte(input t_in_item it);
        logic [4:0] avc_t;
        logic [5:0] hevc_t;
        t_out_item  res;
        if (seen_cnt < SHORT_LIMIT) seen_cnt++;
        if (hdr_next) begin
            avc_t  = it.data_byte[4:0];
            hevc_t = it.data_byte[6:1];
            if (avc_t == AVC_T_SPS || avc_t == AVC_T_PPS) begin
                avc_sc = sat_add(avc_sc, INC_PSET);
            end else if (avc_t inside {AVC_T_SLICE, AVC_T_IDR, AVC_T_SEI, AVC_T_AUD}) begin
                avc_sc = sat_add(avc_sc, INC_ONE);
            end
            if (!it.last_byte) begin
                if (hevc_t inside {HEVC_T_VPS, HEVC_T_SPS, HEVC_T_PPS}) begin
                    hevc_sc = sat_add(hevc_sc, INC_PSET);
                end else if (hevc_t inside {HEVC_T_TRAIL_R, HEVC_T_IDR_W, HEVC_T_IDR_N,
                                            HEVC_T_AUD}) begin
                    hevc_sc = sat_add(hevc_sc, INC_ONE);
                end
            end
            if (codec_sel == CODEC_AVC) begin
                if (avc_t == AVC_T_IDR) idr_flag = 1'b1;
            end else if (hevc_t == HEVC_T_IDR_W || hevc_t == HEVC_T_IDR_N) begin
                idr_flag = 1'b1;
            end
            hdr_next = 1'b0;
            zero_cnt = '0;
        end else if (it.data_byte == START_BYTE && zero_cnt >= ZERO_RUN_MAX) begin
            hdr_next = 1'b1;
            zero_cnt = '0;
        end else if (it.data_byte == ZERO_BYTE) begin
            if (zero_cnt < ZERO_RUN_MAX) zero_cnt++;
        end else begin
            zero_cnt = '0;
        end
        if (it.last_byte) begin
            if (seen_cnt < SHORT_LIMIT) begin
                res.codec_verdict   = VERDICT_NONE;
                res.keyframe_status = KF_SHORT;
            end else begin
                if (avc_sc == '0 && hevc_sc == '0) res.codec_verdict = VERDICT_NONE;
                else if (hevc_sc > avc_sc) res.codec_verdict = VERDICT_HEVC;
                else res.codec_verdict = VERDICT_AVC;
                res.keyframe_status = idr_flag ? KF_IDR : KF_NONE;
            end
            verdict_q.push_back(res);
            n_verdicts_due <= n_verdicts_due + 1;
            zero_cnt = '0;
            hdr_next = 1'b0;
            avc_sc   = '0;
            hevc_sc  = '0;
            idr_flag = 1'b0;
            seen_cnt = '0;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [1:0] got,
                                   input logic [1:0] exp_val);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, exp_val, $realtime);
        fails++;
    endtask

    // byte driver: bursts with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            gap_left   <= 0;
            burst_left <= 0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                predict_byte(i_in_item);
                n_taken <= n_taken + 1;
            end
            if (!i_in_valid || o_in_ready) begin
                if (gap_left != 0) begin
                    gap_left   <= gap_left - 1;
                    i_in_valid <= 1'b0;
                end else if (byte_feed.size() != 0) begin
                    i_in_item  <= byte_feed.pop_front();
                    i_in_valid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 48);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (verdict_q.size() == 0) begin
                    report_mismatch("unexpected transfer", o_out_item.codec_verdict,
                                    VERDICT_NONE);
                end else begin
                    want = verdict_q.pop_front();
                    if (o_out_item.codec_verdict !== want.codec_verdict)
                        report_mismatch("codec_verdict", o_out_item.codec_verdict,
                                        want.codec_verdict);
                    if (o_out_item.keyframe_status !== want.keyframe_status)
                        report_mismatch("keyframe_status", o_out_item.keyframe_status,
                                        want.keyframe_status);
                end
                n_verdicts_got <= n_verdicts_got + 1;
            end
            if (hold_left != 0) begin
                hold_left   <= hold_left - 1;
                i_out_ready <= 1'b0;
            end else if (press_req && !press_done) begin
                hold_left   <= HOLD_CYCLES;
                press_done  <= 1'b1;
                i_out_ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    stall_mode <= $urandom_range(0, 2);
                    mode_left  <= $urandom_range(8, 80);
                end else begin
                    mode_left <= mode_left - 1;
                end
                case (stall_mode)
                    0: i_out_ready <= 1'b1;
                    1: i_out_ready <= ($urandom_range(0, 1) == 1);
                    default: i_out_ready <= ($urandom_range(0, 5) == 0);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic add_byte(input logic [7:0] b, input logic last);
        t_in_item it;
        it.data_byte = b;
        it.last_byte = last;
        byte_feed.push_back(it);
        n_fed++;
    endtask

    task automatic add_nal(input logic [7:0] hdr, input logic last);
        add_byte(ZERO_BYTE, 1'b0);
        add_byte(ZERO_BYTE, 1'b0);
        add_byte(START_BYTE, 1'b0);
        add_byte(hdr, last);
    endtask

    function automatic logic [7:0] pick_noise();
        case ($urandom_range(0, 3))
            0: return ZERO_BYTE;
            1: return START_BYTE;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [7:0] pick_header();
        logic [7:0] r;
        r = 8'($urandom_range(0, 255));
        case ($urandom_range(0, 3))
            0: return {r[7:5], avc_kinds[$urandom_range(0, 5)]};
            1: return {r[7], hevc_kinds[$urandom_range(0, 6)], r[0]};
            default: return r;
        endcase
    endfunction

    task automatic add_random_buffer();
        int         n;
        int         pad;
        int         k;
        int         j;
        logic       tail;
        case ($urandom_range(0, 9))
            0: begin
                n = $urandom_range(1, 3);
                for (j = 0; j < n; j++) add_byte(pick_noise(), j == n - 1);
            end
            1: begin
                n = $urandom_range(4, 24);
                for (j = 0; j < n; j++) add_byte(pick_noise(), j == n - 1);
            end
            default: begin
                n = $urandom_range(1, 5);
                for (k = 0; k < n; k++) begin
                    tail = (k == n - 1);
                    if ($urandom_range(0, 2) == 0) add_byte(ZERO_BYTE, 1'b0);
                    add_byte(ZERO_BYTE, 1'b0);
                    add_byte(ZERO_BYTE, 1'b0);
                    if (tail && $urandom_range(0, 7) == 0) begin
                        add_byte(START_BYTE, 1'b1);
                    end else begin
                        add_byte(START_BYTE, 1'b0);
                        pad = $urandom_range(0, 4);
                        add_byte(pick_header(), tail && pad == 0);
                        for (j = 0; j < pad; j++) add_byte(pick_noise(), tail && j == pad - 1);
                    end
                end
            end
        endcase
    endtask

    task automatic settle();
        while (!(n_taken == n_fed && n_verdicts_got == n_verdicts_due)) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic val);
        logic [31:0] word;
        word    = $urandom();
        word[0] = val;
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_KEYFRAME_CODEC, 2'b00};
        pwdata  <= word;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        codec_sel = val;
    endtask

    initial begin
        int p;
        int target;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // short buffers, header on last byte, start code on last byte, parameter sets
        add_byte(8'hFF, 1'b1);
        add_byte(ZERO_BYTE, 1'b0);
        add_byte(8'hFF, 1'b0);
        add_byte(START_BYTE, 1'b1);
        add_nal(8'h65, 1'b1);
        add_byte(ZERO_BYTE, 1'b0);
        add_byte(ZERO_BYTE, 1'b0);
        add_byte(ZERO_BYTE, 1'b0);
        add_byte(START_BYTE, 1'b1);
        add_nal(8'h40, 1'b0);
        add_nal(8'h42, 1'b0);
        add_byte(8'hAA, 1'b1);
        settle();

        cfg_write(CODEC_HEVC);
        @(negedge i_clk);
        add_nal(8'h26, 1'b1);
        add_nal(8'h65, 1'b0);
        settle();
        // switch codec between buffers
        cfg_write(CODEC_AVC);
        @(negedge i_clk);
        add_nal(8'h26, 1'b0);
        add_byte(8'h77, 1'b1);
        settle();

        target = n_fed;
        for (p = 0; p < RANDOM_PHASES; p++) begin
            cfg_write(p[0]);
            @(negedge i_clk);
            if (p == 1) press_req <= 1'b1;
            target += RANDOM_ITEMS / RANDOM_PHASES;
            while (n_fed < target) add_random_buffer();
            settle();
        end

        if (verdict_q.size() != 0)
            report_mismatch("missing transfer", 2'd0, verdict_q[0].codec_verdict);
        if (fails == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+sv
sv/nalkf_pkg.sv
sv/nalkf_front.sv
sv/nalkf_queue.sv
sv/nalkf_back.sv
sv/annexb_nal_codec_keyframe_scanner.sv
verif/testbench.sv
